// ===== rtl/seer_pkg.sv =====
package seer_pkg;

    localparam logic [7:0] BYTE_ESC      = 8'h1b;
    localparam logic [7:0] BYTE_CR       = 8'h0d;
    localparam logic [7:0] BYTE_LF       = 8'h0a;
    localparam logic [7:0] BYTE_LBRACKET = 8'h5b;
    localparam logic [7:0] BYTE_SEMI     = 8'h3b;
    localparam logic [7:0] BYTE_ONE      = 8'h31;
    localparam logic [7:0] BYTE_TWO      = 8'h32;
    localparam logic [7:0] BYTE_THREE    = 8'h33;
    localparam logic [7:0] BYTE_U        = 8'h75;
    localparam logic [7:0] FINAL_LO      = 8'h40;
    localparam logic [7:0] FINAL_HI      = 8'h7e;

    localparam int unsigned SHIFT_ENTER_LEN = 7;

    // register word index of force_shift (paddr[2])
    localparam logic REG_FORCE_SHIFT = 1'b0;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EMIT = 2'b10
    } t_state;

    typedef enum logic [2:0] {
        MODE_NORMAL = 3'b001,
        MODE_ESC    = 3'b010,
        MODE_CSI    = 3'b100
    } t_mode;

    // what the emit sequencer plays out for one input beat
    typedef enum logic [1:0] {
        JOB_SINGLE,   // saved byte
        JOB_PAIR,     // ESC, saved byte
        JOB_CONST,    // ESC [ 1 3 ; 2 u
        JOB_REPLAY    // ESC, buffered CSI bytes
    } t_job;

    function automatic logic is_final(input logic [7:0] b);
        return b inside {[FINAL_LO:FINAL_HI]};
    endfunction

    function automatic logic [7:0] shift_enter_byte(input logic [2:0] i);
        logic [7:0] r;
        case (i)
            3'd0:    r = BYTE_ESC;
            3'd1:    r = BYTE_LBRACKET;
            3'd2:    r = BYTE_ONE;
            3'd3:    r = BYTE_THREE;
            3'd4:    r = BYTE_SEMI;
            3'd5:    r = BYTE_TWO;
            default: r = BYTE_U;
        endcase
        return r;
    endfunction

    // byte b at position pos of the CSI buffer still fits "[13;2" or "[13;2;1"/"[13;2;2"
    function automatic logic csi_pat_ok(input logic [6:0] pos, input logic [7:0] b);
        logic r;
        case (pos)
            7'd1:    r = (b == BYTE_ONE);
            7'd2:    r = (b == BYTE_THREE);
            7'd3:    r = (b == BYTE_SEMI);
            7'd4:    r = (b == BYTE_TWO);
            7'd5:    r = (b == BYTE_SEMI);
            7'd6:    r = (b == BYTE_ONE) || (b == BYTE_TWO);
            default: r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/shift_enter_escape_rewriter_core.sv =====
// channel   signals                                       beat
// --------  --------------------------------------------  ------------------------------
// input     i_in_valid / o_in_ready                       i_in_byte, i_shift_held
// output    o_out_valid / i_out_ready                     o_out_byte, o_last_of_run
// config    psel penable pwrite paddr pwdata prdata pready force_shift at word 0
//
// An input beat is accepted; its result bytes (0 to SEQ_DEPTH+1) then leave one per
// cycle from the emit sequencer while the output is not stalled. CSI replay reads the
// sequence buffer through its single read port, one entry a cycle unless output stalls.
// o_in_ready is low while the sequencer runs; a stalled output only holds the sequencer.
// Reset (synchronous, i_rst_n low) returns to normal mode with an empty buffer; the
// buffer contents are not cleared since only written entries are ever replayed.
module shift_enter_escape_rewriter_core #(
    parameter int SEQ_DEPTH = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_in_byte,
    input  logic        i_shift_held,

    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_last_of_run,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = $clog2(SEQ_DEPTH);
    localparam int LW = $clog2(SEQ_DEPTH + 1);
    localparam int CW = $clog2(SEQ_DEPTH + 2);

    // config
    logic r_force;

    // parser
    seer_pkg::t_mode  r_mode, n_mode;
    logic [LW-1:0]    r_len, n_len;
    logic             r_ok, n_ok;

    // sequencer
    seer_pkg::t_state r_state, n_state;
    seer_pkg::t_job   r_job, n_job;
    logic [7:0]       r_b, n_b;
    logic [CW-1:0]    r_idx, n_idx;
    logic [CW-1:0]    r_cnt, n_cnt;

    // output register
    logic             r_ovalid, n_ovalid;
    logic [7:0]       r_obyte, n_obyte;
    logic             r_olast, n_olast;

    // sequence buffer
    logic [7:0]       r_mem [SEQ_DEPTH];
    logic [7:0]       r_rdata;
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [7:0]       mem_wdata;
    logic [AW-1:0]    mem_raddr;

    logic             in_acc;
    logic             shift;
    logic [LW-1:0]    len_inc;
    logic             csi_close;
    logic             csi_match;
    logic             push;
    logic             push_last;
    logic [7:0]       tx_byte;

    assign pready      = 1'b1;
    assign prdata      = (paddr[2] == seer_pkg::REG_FORCE_SHIFT) ? {31'b0, r_force} : '0;
    assign o_in_ready  = (r_state == seer_pkg::ST_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_byte  = r_obyte;
    assign o_last_of_run = r_olast;

    assign in_acc    = i_in_valid && o_in_ready;
    assign shift     = i_shift_held || r_force;
    assign len_inc   = r_len + 1'b1;
    assign csi_close = (len_inc == LW'(SEQ_DEPTH)) || seer_pkg::is_final(i_in_byte);
    // r_ok covers entries 1..r_len-1; the closing byte must be 'u' at length 6 or 8
    assign csi_match = r_ok && (i_in_byte == seer_pkg::BYTE_U) &&
                       ((len_inc == LW'(6)) || (len_inc == LW'(8)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_force <= 1'b0;
        end else if (psel && penable && pwrite && pready &&
                     paddr[2] == seer_pkg::REG_FORCE_SHIFT) begin
            r_force <= pwdata[0];
        end
    end

    // parser: decides the job for each accepted beat and fills the buffer
    always_comb begin
        n_mode    = r_mode;
        n_len     = r_len;
        n_ok      = r_ok;
        n_job     = r_job;
        n_b       = r_b;
        n_cnt     = r_cnt;
        mem_we    = 1'b0;
        mem_waddr = r_len[AW-1:0];
        mem_wdata = i_in_byte;
        if (in_acc) begin
            case (r_mode)
                seer_pkg::MODE_ESC: begin
                    if (i_in_byte == seer_pkg::BYTE_LBRACKET) begin
                        n_mode    = seer_pkg::MODE_CSI;
                        n_len     = LW'(1);
                        n_ok      = 1'b1;
                        mem_we    = 1'b1;
                        mem_waddr = '0;
                        mem_wdata = seer_pkg::BYTE_LBRACKET;
                        n_cnt     = '0;
                    end else if (i_in_byte == seer_pkg::BYTE_ESC) begin
                        n_job = seer_pkg::JOB_SINGLE;
                        n_b   = seer_pkg::BYTE_ESC;
                        n_cnt = CW'(1);
                    end else begin
                        n_mode = seer_pkg::MODE_NORMAL;
                        n_job  = seer_pkg::JOB_PAIR;
                        n_b    = i_in_byte;
                        n_cnt  = CW'(2);
                    end
                end
                seer_pkg::MODE_CSI: begin
                    mem_we = 1'b1;
                    n_len  = len_inc;
                    n_ok   = r_ok && seer_pkg::csi_pat_ok(7'(r_len), i_in_byte);
                    n_cnt  = '0;
                    if (csi_close) begin
                        n_mode = seer_pkg::MODE_NORMAL;
                        n_len  = '0;
                        if (csi_match) begin
                            n_job = seer_pkg::JOB_PAIR;
                            n_b   = seer_pkg::BYTE_CR;
                            n_cnt = CW'(2);
                        end else begin
                            n_job = seer_pkg::JOB_REPLAY;
                            n_cnt = CW'(len_inc) + CW'(1);
                        end
                    end
                end
                default: begin
                    n_mode = seer_pkg::MODE_NORMAL;
                    n_cnt  = '0;
                    if (i_in_byte == seer_pkg::BYTE_ESC) begin
                        n_mode = seer_pkg::MODE_ESC;
                    end else if ((i_in_byte == seer_pkg::BYTE_CR ||
                                  i_in_byte == seer_pkg::BYTE_LF) && shift) begin
                        n_job = seer_pkg::JOB_CONST;
                        n_cnt = CW'(seer_pkg::SHIFT_ENTER_LEN);
                    end else begin
                        n_job = seer_pkg::JOB_SINGLE;
                        n_b   = i_in_byte;
                        n_cnt = CW'(1);
                    end
                end
            endcase
        end
    end

    always_comb begin
        case (r_job)
            seer_pkg::JOB_SINGLE: tx_byte = r_b;
            seer_pkg::JOB_PAIR:   tx_byte = (r_idx == '0) ? seer_pkg::BYTE_ESC : r_b;
            seer_pkg::JOB_CONST:  tx_byte = seer_pkg::shift_enter_byte(r_idx[2:0]);
            default:              tx_byte = (r_idx == '0) ? seer_pkg::BYTE_ESC : r_rdata;
        endcase
    end

    assign push      = (r_state == seer_pkg::ST_EMIT) && (!r_ovalid || i_out_ready);
    assign push_last = push && (r_idx == r_cnt - 1'b1);

    // sequencer and output register
    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_ovalid = r_ovalid;
        n_obyte  = r_obyte;
        n_olast  = r_olast;
        if (r_ovalid && i_out_ready) begin
            n_ovalid = 1'b0;
        end
        case (r_state)
            seer_pkg::ST_IDLE: begin
                n_idx = '0;
                if (in_acc && n_cnt != '0) begin
                    n_state = seer_pkg::ST_EMIT;
                end
            end
            seer_pkg::ST_EMIT: begin
                if (push) begin
                    n_ovalid = 1'b1;
                    n_obyte  = tx_byte;
                    n_olast  = push_last;
                    n_idx    = r_idx + 1'b1;
                    if (push_last) begin
                        n_state = seer_pkg::ST_IDLE;
                        n_idx   = '0;
                    end
                end
            end
            default: begin
                n_state = seer_pkg::ST_IDLE;
                n_idx   = '0;
            end
        endcase
    end

    // prefetch: r_rdata always holds entry r_idx-1 for the replay position r_idx
    assign mem_raddr = (n_idx == '0) ? '0 : AW'(n_idx - 1'b1);

    // writes happen only on input beats (idle), reads only matter while emitting
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= seer_pkg::MODE_NORMAL;
            r_len    <= '0;
            r_state  <= seer_pkg::ST_IDLE;
            r_job    <= seer_pkg::JOB_SINGLE;
            r_idx    <= '0;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_mode   <= n_mode;
            r_len    <= n_len;
            r_state  <= n_state;
            r_job    <= n_job;
            r_idx    <= n_idx;
            r_cnt    <= n_cnt;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ok    <= n_ok;
        r_b     <= n_b;
        r_obyte <= n_obyte;
        r_olast <= n_olast;
    end

    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == seer_pkg::ST_EMIT) |-> (r_idx < r_cnt))
        else $error("emit index past byte count");

    a_csi_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == seer_pkg::MODE_CSI) |-> (r_len != '0 && r_len < LW'(SEQ_DEPTH)))
        else $error("CSI length out of range");

    a_esc_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode != seer_pkg::MODE_CSI) |-> (r_len == '0))
        else $error("buffer length nonzero outside CSI");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push_last |=> (o_out_valid && o_last_of_run && r_state == seer_pkg::ST_IDLE))
        else $error("last byte did not close the run");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == seer_pkg::ST_EMIT) |-> !mem_we)
        else $error("buffer written while replaying");

endmodule
